@@ src/sapg_pkg.sv @@
`timescale 1ns / 1ps

package sapg_pkg;

  localparam int PULSE_BITS_DEF = 12;
  localparam int GAP_BITS_DEF   = 16;

  localparam int ANGLE_BITS = 9;
  localparam int FUNC_BITS  = 2;
  localparam int VALUE_BITS = 16;
  localparam int ADDR_BITS  = 2;

  localparam int RESET_MIN_PULSE = 1000;
  localparam int RESET_MAX_PULSE = 2000;
  localparam int RESET_MAX_ANGLE = 180;
  localparam int RESET_GAP_MS    = 18;
  localparam int US_PER_MS       = 1000;
  localparam int RESET_ANGLE     = 90;
  localparam int MIDPOINT_DIV    = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_SET_ANGLE = 2'd1,
    FUNC_SET_PULSE = 2'd2,
    FUNC_SET_EN    = 2'd3
  } func_t;

  typedef enum logic [ADDR_BITS-1:0] {
    REG_MIN_PULSE = 2'd0,
    REG_MAX_PULSE = 2'd1,
    REG_MAX_ANGLE = 2'd2,
    REG_LOW_GAP   = 2'd3
  } reg_addr_t;

endpackage

@@ src/servo_angle_pulse_generator.sv @@
// A tick or an enable item goes straight to the result state. An angle command is
// multiplied and divided to a width; that width or a pulse-width command is clamped and
// mapped back to an angle, all on the shared bit-serial multiplier and divider.
// One item is worked on at a time; the next is taken once the result is registered.
// Reset (synchronous, rst_n low) loads the default registers, a midpoint pulse width,
// an angle of 90 and leaves the output disabled with the pin low.
`timescale 1ns / 1ps

module servo_angle_pulse_generator #(
  parameter int PULSE_BITS = sapg_pkg::PULSE_BITS_DEF,
  parameter int GAP_BITS   = sapg_pkg::GAP_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [sapg_pkg::VALUE_BITS-1:0]      in_tdata,   // value
  input  logic [7:0]                           in_tuser,   // func
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pin_level, angle_now, pulse_now, enabled_now, zero fill
  output logic [((PULSE_BITS+sapg_pkg::ANGLE_BITS+2+7)/8)*8-1:0] out_tdata,
  input  logic                                 cfg_we,
  input  logic [sapg_pkg::ADDR_BITS-1:0]       cfg_addr,
  input  logic [((PULSE_BITS > GAP_BITS) ?
                 ((PULSE_BITS > sapg_pkg::ANGLE_BITS) ? PULSE_BITS : sapg_pkg::ANGLE_BITS) :
                 ((GAP_BITS > sapg_pkg::ANGLE_BITS) ? GAP_BITS : sapg_pkg::ANGLE_BITS))-1:0]
                                               cfg_wdata
);
  import sapg_pkg::*;

  localparam int PB     = PULSE_BITS;
  localparam int AB     = ANGLE_BITS;
  localparam int W      = (PB > AB) ? PB : AB;
  localparam int PW     = PB + AB;
  localparam int WW     = (PB + 1 > VALUE_BITS) ? PB + 1 : VALUE_BITS;
  localparam int CMPW   = (GAP_BITS > PB) ? GAP_BITS : PB;
  localparam int CNTW   = $clog2(W + 1);
  localparam int OUTB   = PB + AB + 2;
  localparam int OUTTW  = ((OUTB + 7) / 8) * 8;

  localparam logic [PB-1:0]       RST_MIN   = PB'(RESET_MIN_PULSE);
  localparam logic [PB-1:0]       RST_MAX   = PB'(RESET_MAX_PULSE);
  localparam logic [PB-1:0]       RST_PULSE = PB'((int'(RST_MIN) + int'(RST_MAX)) / MIDPOINT_DIV);
  localparam logic [AB-1:0]       RST_ANG   = AB'(RESET_MAX_ANGLE);
  localparam logic [GAP_BITS-1:0] RST_GAP   = GAP_BITS'(RESET_GAP_MS * US_PER_MS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_DIV1, ST_APPLY, ST_MUL2, ST_DIV2, ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [PB-1:0]        min_r, min_nxt, max_r, max_nxt;
  logic [AB-1:0]        maxang_r, maxang_nxt;
  logic [GAP_BITS-1:0]  gap_r, gap_nxt;
  logic [PB-1:0]        pulse_r, pulse_nxt, latched_r, latched_nxt;
  logic [AB-1:0]        angle_r, angle_nxt;
  logic                 en_r, en_nxt, high_r, high_nxt;
  logic [GAP_BITS-1:0]  pc_r, pc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUTTW-1:0]     out_data_r, out_data_nxt;

  logic [PW-1:0]        acc_r, acc_nxt;
  logic [W-1:0]         rem_r, rem_nxt, div_r, div_nxt;
  logic [PB-1:0]        mcand_r, mcand_nxt;
  logic [AB-1:0]        mplier_r, mplier_nxt;
  logic [WW-1:0]        w_r, w_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;

  func_t                func;
  logic [GAP_BITS-1:0]  pc_inc;
  logic [PW-1:0]        mul_step, div_step;
  logic [W:0]           trial;
  logic                 trial_ge;
  logic [W-1:0]         rem_step;
  logic [AB-1:0]        ang_clamp;
  logic [PB-1:0]        span;
  logic [WW-1:0]        w_lo, w_hi;
  logic [PB-1:0]        w_clamp;
  logic                 range_ok;

  assign func      = func_t'(in_tuser[FUNC_BITS-1:0]);
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign pc_inc   = pc_r + GAP_BITS'(1);
  assign range_ok = (max_r > min_r);
  assign span     = range_ok ? (max_r - min_r) : '0;
  assign ang_clamp = (in_tdata > VALUE_BITS'(maxang_r)) ? maxang_r : in_tdata[AB-1:0];

  assign mul_step = {acc_r[PW-2:0], 1'b0} + (mplier_r[AB-1] ? PW'(mcand_r) : '0);
  assign trial    = {rem_r, acc_r[PW-1]};
  assign trial_ge = (trial >= {1'b0, div_r});
  assign rem_step = trial_ge ? W'(trial - {1'b0, div_r}) : trial[W-1:0];
  assign div_step = {acc_r[PW-2:0], trial_ge};

  assign w_lo    = (w_r < WW'(min_r)) ? WW'(min_r) : w_r;
  assign w_hi    = (w_lo > WW'(max_r)) ? WW'(max_r) : w_lo;
  assign w_clamp = w_hi[PB-1:0];

  always_comb begin
    state_nxt     = state_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    maxang_nxt    = maxang_r;
    gap_nxt       = gap_r;
    pulse_nxt     = pulse_r;
    latched_nxt   = latched_r;
    angle_nxt     = angle_r;
    en_nxt        = en_r;
    high_nxt      = high_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    w_nxt         = w_r;
    cnt_nxt       = cnt_r;

    if (cfg_we) begin
      case (reg_addr_t'(cfg_addr))
        REG_MIN_PULSE: min_nxt    = cfg_wdata[PB-1:0];
        REG_MAX_PULSE: max_nxt    = cfg_wdata[PB-1:0];
        REG_MAX_ANGLE: maxang_nxt = cfg_wdata[AB-1:0];
        REG_LOW_GAP:   gap_nxt    = cfg_wdata[GAP_BITS-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (func)
            FUNC_TICK: begin
              state_nxt = ST_DONE;
              if (en_r) begin
                pc_nxt = pc_inc;
                if (high_r) begin
                  if (CMPW'(pc_inc) >= CMPW'(latched_r)) begin
                    high_nxt = 1'b0;
                    pc_nxt   = '0;
                  end
                end else if (pc_inc >= gap_r) begin
                  latched_nxt = pulse_r;
                  pc_nxt      = '0;
                  high_nxt    = |pulse_r;
                end
              end
            end
            FUNC_SET_ANGLE: begin
              if (maxang_r == '0) begin
                w_nxt     = WW'(min_r);
                state_nxt = ST_APPLY;
              end else begin
                mcand_nxt  = span;
                mplier_nxt = ang_clamp;
                acc_nxt    = '0;
                cnt_nxt    = CNTW'(AB);
                state_nxt  = ST_MUL1;
              end
            end
            FUNC_SET_PULSE: begin
              w_nxt     = WW'(in_tdata);
              state_nxt = ST_APPLY;
            end
            FUNC_SET_EN: begin
              state_nxt = ST_DONE;
              if (in_tdata != '0) begin
                if (!en_r) begin
                  en_nxt      = 1'b1;
                  latched_nxt = pulse_r;
                  pc_nxt      = '0;
                  high_nxt    = |pulse_r;
                end
              end else begin
                en_nxt   = 1'b0;
                high_nxt = 1'b0;
                pc_nxt   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL1, ST_MUL2: begin
        acc_nxt    = mul_step;
        mplier_nxt = {mplier_r[AB-2:0], 1'b0};
        cnt_nxt    = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          if (state_r == ST_MUL1) begin
            rem_nxt   = W'(mul_step[PW-1:PB]);
            acc_nxt   = mul_step << AB;
            div_nxt   = W'(maxang_r);
            cnt_nxt   = CNTW'(PB);
            state_nxt = ST_DIV1;
          end else begin
            rem_nxt   = W'(mul_step[PW-1:AB]);
            acc_nxt   = mul_step << PB;
            div_nxt   = W'(max_r - min_r);
            cnt_nxt   = CNTW'(AB);
            state_nxt = ST_DIV2;
          end
        end
      end
      ST_DIV1, ST_DIV2: begin
        acc_nxt = div_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          if (state_r == ST_DIV1) begin
            w_nxt     = WW'(min_r) + WW'(div_step[PB-1:0]);
            state_nxt = ST_APPLY;
          end else begin
            angle_nxt = div_step[AB-1:0];
            state_nxt = ST_DONE;
          end
        end
      end
      ST_APPLY: begin
        pulse_nxt = w_clamp;
        if (range_ok) begin
          mcand_nxt  = w_clamp - min_r;
          mplier_nxt = maxang_r;
          acc_nxt    = '0;
          cnt_nxt    = CNTW'(AB);
          state_nxt  = ST_MUL2;
        end else begin
          angle_nxt = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUTTW'({en_r, pulse_r, angle_r, en_r && high_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_r       <= RST_MIN;
      max_r       <= RST_MAX;
      maxang_r    <= RST_ANG;
      gap_r       <= RST_GAP;
      pulse_r     <= RST_PULSE;
      latched_r   <= '0;
      angle_r     <= AB'(RESET_ANGLE);
      en_r        <= 1'b0;
      high_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      maxang_r    <= maxang_nxt;
      gap_r       <= gap_nxt;
      pulse_r     <= pulse_nxt;
      latched_r   <= latched_nxt;
      angle_r     <= angle_nxt;
      en_r        <= en_nxt;
      high_r      <= high_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    w_r      <= w_nxt;
    cnt_r    <= cnt_nxt;
  end

endmodule

@@ verif/tb_servo_angle_pulse_generator.sv @@
`timescale 1ns / 1ps

module tb_servo_angle_pulse_generator;
  import sapg_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 160;

  typedef struct packed {
    logic       pin;
    logic [8:0] angle;
    logic [11:0] pulse;
    logic       en;
  } servo_result_t;

  typedef struct {
    bit            is_cfg;
    func_t         func;
    reg_addr_t     addr;
    bit [15:0]     data;
    bit            typed;
    servo_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [7:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  servo_angle_pulse_generator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the registers and the servo state.
  bit [11:0] min_us, max_us, width_q, latched_q;
  bit [8:0]  angle_lim, angle_q;
  bit [15:0] gap_ticks, count_q;
  bit        enabled_q, high_q;

  servo_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  int            errors = 0;
  int            quiet = 0;
  bit            no_idle = 0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic void servo_reset();
    min_us    = 12'(RESET_MIN_PULSE);
    max_us    = 12'(RESET_MAX_PULSE);
    angle_lim = 9'(RESET_MAX_ANGLE);
    gap_ticks = 16'(RESET_GAP_MS * US_PER_MS);
    width_q   = 12'((RESET_MIN_PULSE + RESET_MAX_PULSE) / MIDPOINT_DIV);
    angle_q   = 9'(RESET_ANGLE);
    enabled_q = 1'b0;
    high_q    = 1'b0;
    count_q   = '0;
    latched_q = '0;
  endfunction

  function automatic void servo_write(reg_addr_t addr, bit [15:0] data);
    case (addr)
      REG_MIN_PULSE: min_us = data[11:0];
      REG_MAX_PULSE: max_us = data[11:0];
      REG_MAX_ANGLE: angle_lim = data[8:0];
      REG_LOW_GAP:   gap_ticks = data;
      default: ;
    endcase
  endfunction

  function automatic void clamp_width(int unsigned w);
    int unsigned prod;
    if (w < min_us) w = min_us;
    if (w > max_us) w = max_us;
    width_q = w[11:0];
    if (max_us > min_us && width_q >= min_us) begin
      prod = (int'(width_q) - int'(min_us)) * int'(angle_lim);
      angle_q = 9'(prod / (int'(max_us) - int'(min_us)));
    end else begin
      angle_q = '0;
    end
  endfunction

  function automatic void begin_period();
    latched_q = width_q;
    count_q   = '0;
    high_q    = (width_q != 0);
  endfunction

  function automatic servo_result_t servo_step(func_t func, bit [15:0] value);
    int unsigned a, span, w;
    servo_result_t r;
    case (func)
      FUNC_TICK: begin
        if (enabled_q) begin
          count_q = count_q + 16'd1;
          if (high_q) begin
            if (count_q >= latched_q) begin
              high_q  = 1'b0;
              count_q = '0;
            end
          end else if (count_q >= gap_ticks) begin
            begin_period();
          end
        end
      end
      FUNC_SET_ANGLE: begin
        a = (value > angle_lim) ? angle_lim : value;
        span = (max_us > min_us) ? (int'(max_us) - int'(min_us)) : 0;
        w = min_us;
        if (angle_lim != 0) w += (span * a) / angle_lim;
        clamp_width(w);
      end
      FUNC_SET_PULSE: clamp_width(value);
      default: begin
        if (value != 0) begin
          if (!enabled_q) begin
            enabled_q = 1'b1;
            begin_period();
          end
        end else begin
          enabled_q = 1'b0;
          high_q    = 1'b0;
          count_q   = '0;
        end
      end
    endcase
    r.pin   = enabled_q && high_q;
    r.angle = angle_q;
    r.pulse = width_q;
    r.en    = enabled_q;
    return r;
  endfunction

  task automatic send_item(func_t func, bit [15:0] value, bit typed, servo_result_t typed_res);
    int gap;
    servo_result_t r;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= {6'd0, func};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = servo_step(func, value);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(reg_addr_t addr, bit [15:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    servo_write(addr, data);
    @(posedge clk);
  endtask

  function automatic void add_cfg(reg_addr_t addr, bit [15:0] data);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.func   = FUNC_TICK;
    row.addr   = addr;
    row.data   = data;
    row.typed  = 1'b0;
    row.res    = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_item(func_t func, bit [15:0] value, bit typed,
                                   servo_result_t res);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.func   = func;
    row.addr   = REG_MIN_PULSE;
    row.data   = value;
    row.typed  = typed;
    row.res    = res;
    directed_rows.push_back(row);
  endfunction

  function automatic bit [15:0] rand_value(func_t func);
    case (func)
      FUNC_SET_ANGLE:
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
      FUNC_SET_PULSE:
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80));
      FUNC_SET_EN: begin
        if ($urandom_range(0, 2) == 0) return 16'd0;
        return ($urandom_range(0, 1) == 0) ? 16'd1 : 16'($urandom);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic func_t rand_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) return FUNC_TICK;
    if (r < 72) return FUNC_SET_ANGLE;
    if (r < 82) return FUNC_SET_PULSE;
    return FUNC_SET_EN;
  endfunction

  always @(posedge clk) begin
    servo_result_t seen, want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[22:0];
      seen.pin   = out_tdata[0];
      seen.angle = out_tdata[9:1];
      seen.pulse = out_tdata[21:10];
      seen.en    = out_tdata[22];
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %h", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (seen.pin !== want.pin)
          report($sformatf("pin_level %b, expected %b", seen.pin, want.pin));
        if (seen.angle !== want.angle)
          report($sformatf("angle_now %0d, expected %0d", seen.angle, want.angle));
        if (seen.pulse !== want.pulse)
          report($sformatf("pulse_now %0d, expected %0d", seen.pulse, want.pulse));
        if (seen.en !== want.en)
          report($sformatf("enabled_now %b, expected %b", seen.en, want.en));
      end
    end
  end

  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    bit [15:0] lo, hi;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    servo_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_item(FUNC_TICK,      16'd0,      1, {1'b0, 9'd90,  12'd1500, 1'b0});
    add_item(FUNC_SET_ANGLE, 16'd0,      1, {1'b0, 9'd0,   12'd1000, 1'b0});
    add_item(FUNC_SET_ANGLE, 16'd180,    1, {1'b0, 9'd180, 12'd2000, 1'b0});
    add_item(FUNC_SET_ANGLE, 16'hFFFF,   1, {1'b0, 9'd180, 12'd2000, 1'b0});
    add_item(FUNC_SET_PULSE, 16'd0,      1, {1'b0, 9'd0,   12'd1000, 1'b0});
    add_item(FUNC_SET_PULSE, 16'hFFFF,   1, {1'b0, 9'd180, 12'd2000, 1'b0});
    add_item(FUNC_SET_PULSE, 16'd1500,   1, {1'b0, 9'd90,  12'd1500, 1'b0});
    add_item(FUNC_SET_EN,    16'd1,      1, {1'b1, 9'd90,  12'd1500, 1'b1});
    add_item(FUNC_SET_EN,    16'hFFFF,   1, {1'b1, 9'd90,  12'd1500, 1'b1});
    add_item(FUNC_TICK,      16'hFFFF,   1, {1'b1, 9'd90,  12'd1500, 1'b1});
    add_item(FUNC_SET_EN,    16'd0,      1, {1'b0, 9'd90,  12'd1500, 1'b0});
    // An angle limit of zero maps every angle to the minimum pulse.
    add_cfg(REG_MAX_ANGLE, 16'd0);
    add_item(FUNC_SET_ANGLE, 16'd90,     1, {1'b0, 9'd0,   12'd1000, 1'b0});
    // A zero-width pulse and a zero gap.
    add_cfg(REG_MIN_PULSE, 16'd0);
    add_cfg(REG_LOW_GAP, 16'd0);
    add_item(FUNC_SET_PULSE, 16'd0,      1, {1'b0, 9'd0,   12'd0,    1'b0});
    add_item(FUNC_SET_EN,    16'd1,      1, {1'b0, 9'd0,   12'd0,    1'b1});
    add_item(FUNC_TICK,      16'd0,      1, {1'b0, 9'd0,   12'd0,    1'b1});
    add_item(FUNC_SET_PULSE, 16'd2,      1, {1'b0, 9'd0,   12'd2,    1'b1});
    add_item(FUNC_TICK,      16'd0,      0, '0);
    add_item(FUNC_TICK,      16'd0,      0, '0);
    add_item(FUNC_TICK,      16'd0,      0, '0);
    add_item(FUNC_SET_EN,    16'd0,      1, {1'b0, 9'd0,   12'd2,    1'b0});
    // Equal and then inverted pulse limits.
    add_cfg(REG_MIN_PULSE, 16'd100);
    add_cfg(REG_MAX_PULSE, 16'd100);
    add_cfg(REG_MAX_ANGLE, 16'd360);
    add_item(FUNC_SET_ANGLE, 16'd200,    1, {1'b0, 9'd0,   12'd100,  1'b0});
    add_cfg(REG_MIN_PULSE, 16'd200);
    add_item(FUNC_SET_PULSE, 16'd150,    1, {1'b0, 9'd0,   12'd100,  1'b0});
    add_item(FUNC_SET_ANGLE, 16'd360,    1, {1'b0, 9'd0,   12'd100,  1'b0});
    add_cfg(REG_MIN_PULSE, 16'd0);
    add_cfg(REG_MAX_PULSE, 16'd4095);
    add_cfg(REG_LOW_GAP, 16'hFFFF);
    add_item(FUNC_SET_ANGLE, 16'd180,    0, '0);
    add_item(FUNC_SET_PULSE, 16'd4095,   1, {1'b0, 9'd360, 12'd4095, 1'b0});

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain();
        write_reg(directed_rows[i].addr, directed_rows[i].data);
      end else begin
        send_item(directed_rows[i].func, directed_rows[i].data,
                  directed_rows[i].typed, directed_rows[i].res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      no_idle = ($urandom_range(0, 3) == 0);
      case (p)
        0: begin
          write_reg(REG_MIN_PULSE, 16'd0);
          write_reg(REG_MAX_PULSE, 16'd4095);
          write_reg(REG_MAX_ANGLE, 16'd360);
          write_reg(REG_LOW_GAP, 16'hFFFF);
        end
        1: begin
          write_reg(REG_MIN_PULSE, 16'd4095);
          write_reg(REG_MAX_PULSE, 16'd0);
          write_reg(REG_MAX_ANGLE, 16'd1);
          write_reg(REG_LOW_GAP, 16'd1);
        end
        default: begin
          lo = 16'($urandom_range(0, 40));
          hi = 16'($urandom_range(0, 60));
          write_reg(REG_MIN_PULSE, lo);
          write_reg(REG_MAX_PULSE, hi);
          case ($urandom_range(0, 3))
            0: write_reg(REG_MAX_ANGLE, 16'd0);
            1: write_reg(REG_MAX_ANGLE, 16'd360);
            default: write_reg(REG_MAX_ANGLE, 16'($urandom_range(1, 360)));
          endcase
          write_reg(REG_LOW_GAP, 16'($urandom_range(0, 25)));
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        func_t f;
        f = rand_func();
        send_item(f, rand_value(f), 1'b0, '0);
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sapg_pkg.sv
src/servo_angle_pulse_generator.sv
verif/tb_servo_angle_pulse_generator.sv
